FILE: rtl/per_pixel_median_of_frames_defines.svh
// Assertion macros for the per-pixel temporal median block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PER_PIXEL_MEDIAN_OF_FRAMES_DEFINES_SVH
`define PER_PIXEL_MEDIAN_OF_FRAMES_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock outside reset
`define MPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpf check failed: same-cycle implication");

// Next-cycle implication, checked on every clock outside reset
`define MPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpf check failed: next-cycle implication");

`else

`define MPF_ASSERT_NOW(lbl, ante, cons)
`define MPF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/mpf_pkg.sv
// Shared types and constants for the per-pixel temporal median block.
// No dependencies; compiled before the interfaces and modules.
package mpf_pkg;

  // Capacity of the sorting chain (samples kept per pixel), 1 to 63
  localparam int MAX_FRAMES = 32;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;   // width of the reported sample count
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  // One pixel: three colour bytes
  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } pix_t;

  // One flag per colour channel
  typedef struct packed {
    logic blue;
    logic green;
    logic red;
  } flag_t;

  typedef enum logic {
    ST_LOAD,
    ST_PICK
  } state_t;

endpackage

FILE: rtl/mpf_if.sv
// Valid/ready channel interfaces for the per-pixel temporal median block.
// Depends on mpf_pkg for the byte and count widths.
interface mpf_in_if;
  import mpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] red;
  logic              last_sample;

  modport source (output valid, blue, green, red, last_sample, input ready);
  modport sink   (input valid, blue, green, red, last_sample, output ready);
endinterface

interface mpf_out_if;
  import mpf_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  median_blue;
  logic [BYTE_W-1:0]  median_green;
  logic [BYTE_W-1:0]  median_red;
  logic [COUNT_W-1:0] sample_count;
  logic               overflow;

  modport source (output valid, median_blue, median_green, median_red, sample_count,
                  overflow, input ready);
  modport sink   (input valid, median_blue, median_green, median_red, sample_count,
                  overflow, output ready);
endinterface

FILE: rtl/per_pixel_median_of_frames.sv
// Per-pixel temporal median: a chain of insertion-sort slots plus control and result register.
// Depends on mpf_pkg, mpf_if.sv, mpf_cell and per_pixel_median_of_frames_defines.svh.
//
// Usage: one pixel position at a time. Each beat on the samples channel carries
// that pixel's blue, green and red bytes from one frame; last_sample marks the
// final frame. The result channel then gives one beat per pixel: the element at
// sorted index count/2 of each channel (upper median for an even count), the
// number of samples kept and an overflow flag if samples past MAX_FRAMES were
// dropped.
// Throughput: one sample beat per cycle while loading; every slot compares and
// shifts in parallel, so the whole chain takes each insertion at once. After the
// last sample the block moves to its pick state, which copies the median slot into
// the result register.
// Reset clears the count, the overflow flag and the result valid flag; slot
// contents and result data are not cleared, only slots below the count are ever read.
// Receiver stall: samples for the next pixel keep being taken while a result
// waits; the pick state waits until the result register is free, taking no samples.
`include "per_pixel_median_of_frames_defines.svh"

module per_pixel_median_of_frames (
  input  logic clk,
  input  logic rst,
  mpf_in_if.sink    samples,
  mpf_out_if.source result
);
  import mpf_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic               dropped;
  logic               in_fire;
  logic               full;
  logic               ins;
  logic               pick;
  logic [CNT_W-1:0]   mid;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  pix_t               sample;
  pix_t               cell_val [MAX_FRAMES];
  flag_t              cell_gt  [MAX_FRAMES];

  assign sample  = '{blue: samples.blue, green: samples.green, red: samples.red};
  assign full    = (count == CNT_W'(MAX_FRAMES));
  assign in_fire = samples.valid && samples.ready;
  assign ins     = in_fire && !full;
  assign mid     = count >> 1;
  assign idx     = mid[IDX_W-1:0];
  assign cnt_ext = {{COUNT_W{1'b0}}, count};

  // Sorting chain
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    pix_t  left_val;
    flag_t left_gt;
    if (i == 0) begin : g_head
      assign left_val = sample;
      assign left_gt  = '0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    mpf_cell u_cell (
      .clk      (clk),
      .load     (ins),
      .occ      (CNT_W'(i) < count),
      .sample   (sample),
      .left_val (left_val),
      .left_gt  (left_gt),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  // Control: next state and handshakes
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    pick          = 1'b0;
    case (state)
      ST_LOAD: begin
        samples.ready = 1'b1;
        if (samples.valid && samples.last_sample) state_next = ST_PICK;
      end
      ST_PICK: begin
        pick = !result.valid || result.ready;
        if (pick) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sample count and overflow flag, cleared once the result is picked
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (pick) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (in_fire) begin
      if (full) dropped <= 1'b1;
      else      count   <= count + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pick) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      result.median_blue  <= cell_val[idx].blue;
      result.median_green <= cell_val[idx].green;
      result.median_red   <= cell_val[idx].red;
      result.sample_count <= cnt_ext[COUNT_W-1:0];
      result.overflow     <= dropped;
    end
  end

  // Checks
  `MPF_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_FRAMES))
  `MPF_ASSERT_NEXT(a_last_to_pick, in_fire && samples.last_sample, state == ST_PICK)
  `MPF_ASSERT_NEXT(a_pick_clears, pick, result.valid && count == '0 && !dropped)
  `MPF_ASSERT_NEXT(a_drop_flags, in_fire && full && !samples.last_sample, dropped)
  `MPF_ASSERT_NEXT(a_pick_count, pick, result.sample_count == $past(cnt_ext[COUNT_W-1:0]))

endmodule

FILE: rtl/mpf_cell.sv
// One slot of the insertion-sort chain: holds one sorted entry per colour channel.
// Depends on mpf_pkg for pix_t and flag_t.
module mpf_cell (
  input  logic         clk,
  input  logic         load,
  input  logic         occ,
  input  mpf_pkg::pix_t  sample,
  input  mpf_pkg::pix_t  left_val,
  input  mpf_pkg::flag_t left_gt,
  output mpf_pkg::pix_t  val,
  output mpf_pkg::flag_t gt
);
  import mpf_pkg::*;

  // Empty slots count as larger than any sample
  always_comb begin
    gt.blue  = !occ || (val.blue  > sample.blue);
    gt.green = !occ || (val.green > sample.green);
    gt.red   = !occ || (val.red   > sample.red);
  end

  // Slot shifts up from its left neighbour, or takes the new sample at the insert point
  always_ff @(posedge clk) begin
    if (load) begin
      if (gt.blue)  val.blue  <= left_gt.blue  ? left_val.blue  : sample.blue;
      if (gt.green) val.green <= left_gt.green ? left_val.green : sample.green;
      if (gt.red)   val.red   <= left_gt.red   ? left_val.red   : sample.red;
    end
  end

endmodule
